// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with reset guard.
`define SORS_ASSERT(lbl, clk_s, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) prop) else $error(msg);

// Clocked implication with reset guard.
`define SORS_ASSERT_IMP(lbl, clk_s, rst_n, pre, post, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) (pre) |-> (post)) \
		else $error(msg);

`endif

// ===== design/sors_pkg.sv =====
// ----------------------------------------------------------------------------
// sors_pkg
// Types, codes and constants of the segment obstacle risk scan.
// ----------------------------------------------------------------------------
package sors_pkg;

	localparam int CoordW = 24;
	localparam int DiffW  = 25;
	localparam int WideW  = 52;
	localparam int IdW    = 16;
	localparam int RiskW  = 17;
	localparam int TimeW  = 24;
	localparam int ConfW  = 9;
	localparam int CntW   = 6;

	localparam int InDataW  = 104;
	localparam int OutDataW = 112;

	localparam logic [WideW-1:0] NearLimit = 52'd512;
	localparam logic [10:0]      RiskBase  = 11'd1280;
	localparam logic [24:0]      Recip50   = 25'd21474836;
	localparam logic [17:0]      RiskOne   = 18'd65536;
	localparam logic [23:0]      SlowSpeed = 24'd25;

	localparam logic [CntW-1:0] DivSteps  = 6'd31;
	localparam logic [CntW-1:0] SqrtSteps = 6'd25;
	localparam logic [CntW-1:0] TimeSteps = 6'd16;

	typedef enum logic [1:0] {
		CFG_START_X = 2'd0,
		CFG_START_Y = 2'd1,
		CFG_END_X   = 2'd2,
		CFG_END_Y   = 2'd3
	} cfg_idx_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_MUL_AC,
		OP_MUL_BD,
		OP_MUL_CC,
		OP_MUL_DD,
		OP_NEAR_START,
		OP_NEAR_END,
		OP_DIV_INIT,
		OP_DIV_STEP,
		OP_ALONG_X,
		OP_ALONG_Y,
		OP_SQ_X,
		OP_SQ_Y,
		OP_SQRT_STEP,
		OP_RISK_A,
		OP_RISK_B,
		OP_RISK_C,
		OP_RISK_D,
		OP_FINISH
	} dp_op_t;

	typedef struct packed {
		logic   load;
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic skip;
		logic last;
		logic dot_le0;
		logic dot_ge;
		logic near;
		logic slow;
		logic out_free;
	} dp_stat_t;

endpackage

// ===== design/segment_obstacle_risk_scan_unit.sv =====
// ----------------------------------------------------------------------------
// segment_obstacle_risk_scan_unit
// Scores obstacle reports against a path segment and reports the worst one.
// ----------------------------------------------------------------------------
// Usage:
//   Write the segment end points through cfg_we/cfg_addr/cfg_data while idle.
//   Each input item on s_* is one obstacle report; s_tlast closes a scan.
//   On the closing item one result leaves on m_*: best id, risk, minimum time
//   to collision and the segment midpoint; the scan state then clears.
// Sequencing:
//   One item at a time. A skipped report goes straight to its closing step;
//   only one projected inside the segment runs the 32-step projection divide.
//   The 26-step square root follows, then, for a near and fast obstacle, the
//   17-step time divide. Both divides use one shift-subtract unit, the products
//   one shared multiplier. A result appears the cycle after the closing step.
// Reset:
//   arst_n clears the segment to zero, the scan state and the result valid.
// Stall:
//   The result waits in an output register; the next item is still taken and
//   worked, and only the closing step of a scan's last item waits until the result is taken.
// ----------------------------------------------------------------------------
module segment_obstacle_risk_scan_unit import sors_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_addr,
	input  logic [CoordW-1:0]   cfg_data,
	input  logic                s_tvalid,
	output logic                s_tready,
	// obstacle_id[15:0], pos_x[39:16], pos_y[63:40], confidence[72:64],
	// speed[96:73], zero fill
	input  logic [InDataW-1:0]  s_tdata,
	// is_dynamic[0], skip[1]
	input  logic [1:0]          s_tuser,
	input  logic                s_tlast,
	output logic                m_tvalid,
	input  logic                m_tready,
	// best_id[15:0], risk_level[32:16], time_to_hit[56:33], mid_x[80:57],
	// mid_y[104:81], zero fill
	output logic [OutDataW-1:0] m_tdata,
	// found[0], time_infinite[1]
	output logic [1:0]          m_tuser
);

	dp_cmd_t          cmd;
	dp_stat_t         st;
	logic             found, inf;
	logic [IdW-1:0]   best_id;
	logic [RiskW-1:0] risk;
	logic [TimeW-1:0] t_hit;
	logic [CoordW-1:0] mid_x, mid_y;

	sors_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	sors_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_data  (cfg_data),
		.in_id     (s_tdata[15:0]),
		.in_pos_x  (s_tdata[39:16]),
		.in_pos_y  (s_tdata[63:40]),
		.in_dyn    (s_tuser[0]),
		.in_conf   (s_tdata[72:64]),
		.in_speed  (s_tdata[96:73]),
		.in_skip   (s_tuser[1]),
		.in_last   (s_tlast),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_found (found),
		.out_id    (best_id),
		.out_risk  (risk),
		.out_time  (t_hit),
		.out_inf   (inf),
		.out_mid_x (mid_x),
		.out_mid_y (mid_y)
	);

	assign m_tdata = {7'b0, mid_y, mid_x, t_hit, risk, best_id};
	assign m_tuser = {inf, found};

endmodule

// ===== design/sors_ctrl.sv =====
// ----------------------------------------------------------------------------
// sors_ctrl
// Sequencer that steps the datapath through one obstacle report.
// ----------------------------------------------------------------------------
module sors_ctrl import sors_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  dp_stat_t st,
	output dp_cmd_t  cmd
);

	typedef enum logic [4:0] {
		S_IDLE, S_AC, S_BD, S_CC, S_DD, S_BR, S_DIV, S_ALX, S_ALY,
		S_SQX, S_SQY, S_SQRT, S_RA, S_RB, S_RC, S_RD, S_TDIV, S_FIN
	} state_t;

	state_t          state_q;
	logic [CntW-1:0] cnt_q;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd.load = in_valid && in_ready;
		unique case (state_q)
			S_IDLE: cmd.op = OP_NONE;
			S_AC:   cmd.op = OP_MUL_AC;
			S_BD:   cmd.op = OP_MUL_BD;
			S_CC:   cmd.op = OP_MUL_CC;
			S_DD:   cmd.op = OP_MUL_DD;
			S_BR: begin
				if (st.dot_le0) cmd.op = OP_NEAR_START;
				else if (st.dot_ge) cmd.op = OP_NEAR_END;
				else cmd.op = OP_DIV_INIT;
			end
			S_DIV:  cmd.op = OP_DIV_STEP;
			S_ALX:  cmd.op = OP_ALONG_X;
			S_ALY:  cmd.op = OP_ALONG_Y;
			S_SQX:  cmd.op = OP_SQ_X;
			S_SQY:  cmd.op = OP_SQ_Y;
			S_SQRT: cmd.op = OP_SQRT_STEP;
			S_RA:   cmd.op = OP_RISK_A;
			S_RB:   cmd.op = OP_RISK_B;
			S_RC:   cmd.op = OP_RISK_C;
			S_RD:   cmd.op = OP_RISK_D;
			S_TDIV: cmd.op = OP_DIV_STEP;
			S_FIN:  cmd.op = (st.out_free || !st.last) ? OP_FINISH : OP_NONE;
			default: cmd.op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: if (in_valid) state_q <= S_AC;
				S_AC:   state_q <= st.skip ? S_FIN : S_BD;
				S_BD:   state_q <= S_CC;
				S_CC:   state_q <= S_DD;
				S_DD:   state_q <= S_BR;
				S_BR: begin
					if (st.dot_le0 || st.dot_ge) begin
						state_q <= S_SQX;
					end else begin
						state_q <= S_DIV;
						cnt_q   <= DivSteps;
					end
				end
				S_DIV: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) state_q <= S_ALX;
				end
				S_ALX:  state_q <= S_ALY;
				S_ALY:  state_q <= S_SQX;
				S_SQX:  state_q <= S_SQY;
				S_SQY: begin
					state_q <= S_SQRT;
					cnt_q   <= SqrtSteps;
				end
				S_SQRT: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) state_q <= S_RA;
				end
				// out of range: no score, go close the item
				S_RA:   state_q <= st.near ? S_RB : S_FIN;
				S_RB:   state_q <= S_RC;
				S_RC:   state_q <= S_RD;
				S_RD: begin
					if (st.slow) begin
						state_q <= S_FIN;
					end else begin
						state_q <= S_TDIV;
						cnt_q   <= TimeSteps;
					end
				end
				S_TDIV: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) state_q <= S_FIN;
				end
				S_FIN:  if (st.out_free || !st.last) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== design/sors_dp.sv =====
// ----------------------------------------------------------------------------
// sors_dp
// Datapath: shared multiplier, shift-subtract divider, bitwise square root,
// scan state and the result register.
// ----------------------------------------------------------------------------
module sors_dp import sors_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  dp_cmd_t                    cmd,
	output dp_stat_t                   st,
	input  logic                       cfg_we,
	input  logic [1:0]                 cfg_addr,
	input  logic [CoordW-1:0]          cfg_data,
	input  logic [IdW-1:0]             in_id,
	input  logic signed [CoordW-1:0]   in_pos_x,
	input  logic signed [CoordW-1:0]   in_pos_y,
	input  logic                       in_dyn,
	input  logic [ConfW-1:0]           in_conf,
	input  logic [TimeW-1:0]           in_speed,
	input  logic                       in_skip,
	input  logic                       in_last,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic                       out_found,
	output logic [IdW-1:0]             out_id,
	output logic [RiskW-1:0]           out_risk,
	output logic [TimeW-1:0]           out_time,
	output logic                       out_inf,
	output logic [CoordW-1:0]          out_mid_x,
	output logic [CoordW-1:0]          out_mid_y
);

	logic signed [CoordW-1:0] sx_q, sy_q, ex_q, ey_q;

	logic [IdW-1:0]        id_q;
	logic                  dyn_q, skip_q, last_q;
	logic [ConfW-1:0]      conf_q;
	logic [TimeW-1:0]      speed_q;
	logic signed [DiffW-1:0] a_q, b_q, c_q, d_q;

	logic signed [WideW-1:0] acc_q, dot_q;
	logic [WideW-1:0]        den_q, rem_q, sv_q, res_q, bit_q;
	logic [16:0]             num_q;
	logic [31:0]             q_q;
	logic signed [25:0]      dx_q, dy_q;
	logic [23:0]             numr_q;
	logic [17:0]             qe_q;
	logic [RiskW-1:0]        risk_q;

	logic [RiskW-1:0] max_risk_q;
	logic [IdW-1:0]   best_q;
	logic             have_q;
	logic [TimeW-1:0] min_t_q;
	logic             inf_q;
	logic             out_valid_q;

	logic signed [33:0] ma;
	logic signed [25:0] mb;
	logic signed [59:0] prod;
	logic [24:0]        c_abs, d_abs;
	logic [57:0]        rnd;
	logic signed [25:0] m_s;
	logic [WideW-1:0]   div_t, sq_try;
	logic               div_ge;
	logic [23:0]        qe50, corr;
	logic [17:0]        rq;
	logic [12:0]        t_slow;
	logic [TimeW-1:0]   t_val;
	logic               score, risk_upd, time_upd;
	logic [RiskW-1:0]   nx_risk;
	logic [IdW-1:0]     nx_best;
	logic               nx_have;
	logic [TimeW-1:0]   nx_t;
	logic               nx_inf;
	logic signed [24:0] mid_x_sum, mid_y_sum;

	assign c_abs = c_q[24] ? 25'(-c_q) : 25'(c_q);
	assign d_abs = d_q[24] ? 25'(-d_q) : 25'(d_q);

	// operand select for the shared multiplier
	always_comb begin
		ma = '0;
		mb = '0;
		case (cmd.op)
			OP_MUL_AC: begin ma = 34'(a_q); mb = 26'(c_q); end
			OP_MUL_BD: begin ma = 34'(b_q); mb = 26'(d_q); end
			OP_MUL_CC: begin ma = 34'(c_q); mb = 26'(c_q); end
			OP_MUL_DD: begin ma = 34'(d_q); mb = 26'(d_q); end
			OP_ALONG_X: begin ma = {2'b0, q_q}; mb = {1'b0, c_abs}; end
			OP_ALONG_Y: begin ma = {2'b0, q_q}; mb = {1'b0, d_abs}; end
			OP_SQ_X: begin ma = 34'(dx_q); mb = dx_q; end
			OP_SQ_Y: begin ma = 34'(dy_q); mb = dy_q; end
			OP_RISK_A: begin
				ma = {23'b0, RiskBase - res_q[10:0]};
				mb = {17'b0, conf_q};
			end
			OP_RISK_C: begin ma = {10'b0, numr_q}; mb = {1'b0, Recip50}; end
			default: begin ma = '0; mb = '0; end
		endcase
	end

	assign prod   = ma * mb;
	assign rnd    = prod[57:0] + 58'h0_8000_0000;
	assign m_s    = signed'(rnd[57:32]);
	assign div_t  = {rem_q[50:0], num_q[16]};
	assign div_ge = (div_t >= den_q);
	assign sq_try = res_q + bit_q;
	assign qe50   = {1'b0, qe_q, 5'b0} + {2'b0, qe_q, 4'b0} + {5'b0, qe_q, 1'b0};
	assign corr   = numr_q - qe50;
	assign rq     = qe_q + {17'b0, (corr >= 24'd50)};

	assign st.skip     = skip_q;
	assign st.last     = last_q;
	assign st.dot_le0  = dot_q[WideW-1] || (dot_q == '0);
	assign st.dot_ge   = !dot_q[WideW-1] && (unsigned'(dot_q) >= den_q);
	assign st.near     = (res_q < NearLimit);
	assign st.slow     = (speed_q <= SlowSpeed);
	assign st.out_free = !out_valid_q || out_ready;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sx_q <= '0;
			sy_q <= '0;
			ex_q <= '0;
			ey_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_addr))
				CFG_START_X: sx_q <= cfg_data;
				CFG_START_Y: sy_q <= cfg_data;
				CFG_END_X:   ex_q <= cfg_data;
				CFG_END_Y:   ey_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			id_q    <= in_id;
			dyn_q   <= in_dyn;
			conf_q  <= in_conf;
			speed_q <= in_speed;
			skip_q  <= in_skip;
			last_q  <= in_last;
			a_q     <= 25'(in_pos_x) - 25'(sx_q);
			b_q     <= 25'(in_pos_y) - 25'(sy_q);
			c_q     <= 25'(ex_q) - 25'(sx_q);
			d_q     <= 25'(ey_q) - 25'(sy_q);
		end
		case (cmd.op)
			OP_MUL_AC: acc_q <= prod[WideW-1:0];
			OP_MUL_BD: dot_q <= acc_q + signed'(prod[WideW-1:0]);
			OP_MUL_CC: acc_q <= prod[WideW-1:0];
			OP_MUL_DD: den_q <= unsigned'(acc_q) + prod[WideW-1:0];
			OP_NEAR_START: begin
				dx_q <= 26'(a_q);
				dy_q <= 26'(b_q);
			end
			OP_NEAR_END: begin
				dx_q <= 26'(a_q) - 26'(c_q);
				dy_q <= 26'(b_q) - 26'(d_q);
			end
			OP_DIV_INIT: begin
				rem_q <= unsigned'(dot_q);
				num_q <= '0;
				q_q   <= '0;
			end
			OP_DIV_STEP: begin
				rem_q <= div_ge ? div_t - den_q : div_t;
				q_q   <= {q_q[30:0], div_ge};
				num_q <= {num_q[15:0], 1'b0};
			end
			OP_ALONG_X: dx_q <= 26'(a_q) - (c_q[24] ? -m_s : m_s);
			OP_ALONG_Y: dy_q <= 26'(b_q) - (d_q[24] ? -m_s : m_s);
			OP_SQ_X: acc_q <= prod[WideW-1:0];
			OP_SQ_Y: begin
				sv_q  <= unsigned'(acc_q) + prod[WideW-1:0];
				res_q <= '0;
				bit_q <= {1'b0, 1'b1, 50'b0};
			end
			OP_SQRT_STEP: begin
				if (sv_q >= sq_try) begin
					sv_q  <= sv_q - sq_try;
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			OP_RISK_A: numr_q <= prod[23:0];
			OP_RISK_B: begin
				if (dyn_q) numr_q <= {numr_q[20:0], 3'b0} + {numr_q[21:0], 2'b0}
					+ numr_q + 24'd25;
				else numr_q <= {numr_q[20:0], 3'b0} + {numr_q[22:0], 1'b0} + 24'd25;
			end
			OP_RISK_C: qe_q <= prod[47:30];
			OP_RISK_D: begin
				risk_q <= (rq > RiskOne) ? RiskOne[RiskW-1:0] : rq[RiskW-1:0];
				// set up the time division: d * 256 / speed
				rem_q  <= '0;
				num_q  <= {res_q[8:0], 8'b0};
				den_q  <= {28'b0, speed_q};
				q_q    <= '0;
			end
			default: ;
		endcase
	end

	// closing of one item
	always_comb begin
		t_slow   = {1'b0, res_q[8:0], 3'b0} + {3'b0, res_q[8:0], 1'b0};
		t_val    = st.slow ? {11'b0, t_slow} : {7'b0, q_q[16:0]};
		score    = !skip_q && st.near;
		risk_upd = score && (risk_q > max_risk_q);
		time_upd = score && (speed_q != '0) && (inf_q || (t_val < min_t_q));
		nx_risk  = risk_upd ? risk_q : max_risk_q;
		nx_best  = risk_upd ? id_q : best_q;
		nx_have  = risk_upd || have_q;
		nx_t     = time_upd ? t_val : min_t_q;
		nx_inf   = inf_q && !time_upd;
		mid_x_sum = 25'(sx_q) + 25'(ex_q);
		mid_y_sum = 25'(sy_q) + 25'(ey_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_risk_q  <= '0;
			best_q      <= '0;
			have_q      <= 1'b0;
			min_t_q     <= '0;
			inf_q       <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			if (cmd.op == OP_FINISH) begin
				if (last_q) begin
					out_valid_q <= 1'b1;
					max_risk_q  <= '0;
					best_q      <= '0;
					have_q      <= 1'b0;
					min_t_q     <= '0;
					inf_q       <= 1'b1;
				end else begin
					max_risk_q <= nx_risk;
					best_q     <= nx_best;
					have_q     <= nx_have;
					min_t_q    <= nx_t;
					inf_q      <= nx_inf;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_FINISH && last_q) begin
			out_found <= nx_have;
			out_id    <= nx_have ? nx_best : '0;
			out_risk  <= nx_have ? nx_risk : '0;
			out_time  <= nx_inf ? '0 : nx_t;
			out_inf   <= nx_inf;
			out_mid_x <= mid_x_sum[24:1];
			out_mid_y <= mid_y_sum[24:1];
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== design/sors_checker.sv =====
// ----------------------------------------------------------------------------
// sors_checker
// Port-level checks of the segment obstacle risk scan unit.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sors_checker import sors_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                cfg_we,
	input logic [1:0]          cfg_addr,
	input logic [CoordW-1:0]   cfg_data,
	input logic                s_tvalid,
	input logic                s_tready,
	input logic [InDataW-1:0]  s_tdata,
	input logic [1:0]          s_tuser,
	input logic                s_tlast,
	input logic                m_tvalid,
	input logic                m_tready,
	input logic [OutDataW-1:0] m_tdata,
	input logic [1:0]          m_tuser
);

	`SORS_ASSERT_IMP(a_hold_valid, clk, arst_n, m_tvalid && !m_tready, ##1 m_tvalid, "result dropped while stalled")
	`SORS_ASSERT_IMP(a_busy_after_take, clk, arst_n, s_tvalid && s_tready, ##1 !s_tready, "item taken while busy")
	`SORS_ASSERT_IMP(a_not_found_zero, clk, arst_n, m_tvalid && !m_tuser[0], m_tdata[32:0] == 33'd0, "id or risk set without a find")
	`SORS_ASSERT_IMP(a_inf_zero_time, clk, arst_n, m_tvalid && m_tuser[1], m_tdata[56:33] == 24'd0, "time set while infinite")
	`SORS_ASSERT_IMP(a_risk_cap, clk, arst_n, m_tvalid && m_tdata[32], m_tdata[31:16] == 16'd0, "risk above one")

endmodule

bind segment_obstacle_risk_scan_unit sors_checker u_sors_checker (.*);
